// ----- hw/rtl/ngps_pkg.sv -----
// Shared types and constants for the NMEA position sentence parser.
// Used by the result queue and the top level.
`default_nettype none

package ngps_pkg;

	// Longest accepted sentence in bytes, counting the dollar sign and the newline.
	localparam int unsigned MAX_SENTENCE = 128;
	// Decimal fraction digits kept in the fixed-point values.
	localparam int unsigned FRAC_DIGITS = 4;

	localparam int unsigned CNT_W = 8;
	localparam int unsigned FIELD_W = 5;
	localparam int unsigned FRAC_CNT_W = 3;
	localparam int unsigned SCALE_W = 20;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned PROD_W = VAL_W + SCALE_W;
	localparam int unsigned HDR_DEPTH = 5;

	localparam logic [VAL_W-1:0] MAG_LIMIT = 32'h8000_0000;
	localparam logic [VAL_W-1:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [FIELD_W-1:0] FIELD_MAX = 5'd31;

	// Characters of the sentence syntax.
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [7:0] CH_G = 8'h47;
	localparam logic [7:0] CH_L = 8'h4C;
	localparam logic [7:0] CH_M = 8'h4D;
	localparam logic [7:0] CH_P = 8'h50;
	localparam logic [7:0] CH_R = 8'h52;

	// Sentence kinds as reported on the result channel.
	localparam logic [1:0] KIND_GGA = 2'd0;
	localparam logic [1:0] KIND_GLL = 2'd1;
	localparam logic [1:0] KIND_RMC = 2'd2;

	// Index of the altitude field in a GGA sentence.
	localparam logic [FIELD_W-1:0] GGA_ALT_FIELD = 5'd9;

	typedef struct packed {
		logic [1:0] sentence_kind;
		logic fix_committed;
		logic signed [VAL_W-1:0] latitude_fixed;
		logic [7:0] lat_hemisphere;
		logic signed [VAL_W-1:0] longitude_fixed;
		logic [7:0] lon_hemisphere;
		logic signed [VAL_W-1:0] altitude_fixed;
	} result_t;

	// Field index of the latitude for each sentence kind.
	function automatic logic [FIELD_W-1:0] lat_field(input logic [1:0] kind);
		logic [FIELD_W-1:0] f;
		unique case (kind)
			KIND_GGA: f = 5'd2;
			KIND_GLL: f = 5'd1;
			KIND_RMC: f = 5'd3;
			default: f = 5'd2;
		endcase
		return f;
	endfunction

	// Field index of the status character; GGA has none.
	function automatic logic [FIELD_W-1:0] status_field(input logic [1:0] kind);
		logic [FIELD_W-1:0] f;
		unique case (kind)
			KIND_GLL: f = 5'd6;
			KIND_RMC: f = 5'd2;
			default: f = 5'd0;
		endcase
		return f;
	endfunction

	// Power of ten that pads a number out to the full fraction width.
	function automatic logic [SCALE_W-1:0] pow10(input logic [FRAC_CNT_W-1:0] n);
		logic [SCALE_W-1:0] p;
		unique case (n)
			3'd0: p = 20'd1;
			3'd1: p = 20'd10;
			3'd2: p = 20'd100;
			3'd3: p = 20'd1000;
			3'd4: p = 20'd10000;
			3'd5: p = 20'd100000;
			3'd6: p = 20'd1000000;
			default: p = 20'd1;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ngps_sym_if.sv -----
// Input channel of the NMEA parser: one received byte per word.
// Depends on nothing.
`default_nettype none

interface ngps_sym_if;
	logic valid;
	logic ready;
	logic [7:0] symbol;

	modport source(output valid, output symbol, input ready);
	modport sink(input valid, input symbol, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ngps_res_if.sv -----
// Result channel of the NMEA parser: one finished sentence per word.
// Depends on nothing.
`default_nettype none

interface ngps_res_if;
	logic valid;
	logic ready;
	logic [1:0] sentence_kind;
	logic fix_committed;
	logic signed [31:0] latitude_fixed;
	logic [7:0] lat_hemisphere;
	logic signed [31:0] longitude_fixed;
	logic [7:0] lon_hemisphere;
	logic signed [31:0] altitude_fixed;

	modport source(output valid, output sentence_kind, output fix_committed,
		output latitude_fixed, output lat_hemisphere, output longitude_fixed,
		output lon_hemisphere, output altitude_fixed, input ready);
	modport sink(input valid, input sentence_kind, input fix_committed,
		input latitude_fixed, input lat_hemisphere, input longitude_fixed,
		input lon_hemisphere, input altitude_fixed, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/nmea_gps_sentence_parser_top.sv -----
// NMEA-0183 position sentence parser. Takes one received byte per word and
// returns one result word on the newline of every GGA, GLL or RMC sentence
// with talker GP. A byte is taken every clock cycle: each byte updates the
// parse state as it is taken, and results go into a two-entry queue, so
// input stalls only while two results wait on a stalled sink. Latitude,
// longitude and altitude are reported as the decimal value times 10^4,
// saturated to 32 bits; the hemisphere characters are 0 when their field
// was empty. GLL and RMC update the held position only when their status is
// 'A'. Sentences longer than 128 bytes are dropped without a result.
// Depends on ngps_pkg, ngps_sym_if, ngps_res_if and ngps_outq.
`default_nettype none

module nmea_gps_sentence_parser_top import ngps_pkg::*; (
	input logic clk,
	input logic arst_n,
	ngps_sym_if.sink symbols,
	ngps_res_if.source results
);

	typedef enum logic [2:0] {
		PH_SEARCH,
		PH_TALKER,
		PH_TYPE,
		PH_GGA,
		PH_GLL,
		PH_RMC
	} phase_t;

	phase_t phase_q, phase_nx;
	logic [CNT_W-1:0] char_cnt_q, char_cnt_nx;
	logic [7:0] hdr_q [HDR_DEPTH];
	logic [7:0] hdr_nx [HDR_DEPTH];
	logic [FIELD_W-1:0] field_q, field_nx;
	logic [VAL_W-1:0] acc_q, acc_nx;
	logic neg_q, neg_nx;
	logic point_q, point_nx;
	logic stop_q, stop_nx;
	logic [FRAC_CNT_W-1:0] fcnt_q, fcnt_nx;
	logic begun_q, begun_nx;
	logic [VAL_W-1:0] pend_val_q [3];
	logic [VAL_W-1:0] pend_val_nx [3];
	logic [7:0] pend_side_q [2];
	logic [7:0] pend_side_nx [2];
	logic status_ok_q, status_ok_nx;
	logic [VAL_W-1:0] held_val_q [3];
	logic [VAL_W-1:0] held_val_nx [3];
	logic [7:0] held_side_q [2];
	logic [7:0] held_side_nx [2];

	logic full;
	logic accept;
	logic res_fire;
	result_t res_data;
	result_t pop_data;

	logic [7:0] sym;
	logic is_digit;
	logic [VAL_W+3:0] mul10;
	logic [VAL_W-1:0] acc_digit;
	logic [SCALE_W-1:0] scale;
	logic [PROD_W-1:0] prod;
	logic [VAL_W-1:0] mag;
	logic [VAL_W-1:0] fix_val;
	logic [2:0] hdr_idx;

	assign sym = symbols.symbol;
	assign symbols.ready = !full;
	assign accept = symbols.valid && !full;

	// Accumulator times ten plus the new digit, saturating at 2^31.
	assign is_digit = (sym >= CH_ZERO) && (sym <= CH_NINE);
	assign mul10 = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1)
		+ {28'd0, (sym - CH_ZERO) & 8'h0F};
	assign acc_digit = (mul10 > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : mul10[VAL_W-1:0];

	// The number of the field that just ended, padded to the full fraction width.
	assign scale = pow10(FRAC_CNT_W'(FRAC_DIGITS) - fcnt_q);
	assign prod = PROD_W'(acc_q) * PROD_W'(scale);
	assign mag = (prod > PROD_W'(MAG_LIMIT)) ? MAG_LIMIT : prod[VAL_W-1:0];
	assign fix_val = neg_q ? (VAL_W'(0) - mag) : ((mag >= MAG_LIMIT) ? POS_MAX : mag);

	assign hdr_idx = char_cnt_q[2:0] - 3'd1;

	always_comb begin
		logic [1:0] kind;
		logic [FIELD_W-1:0] latf;
		logic commit;
		phase_nx = phase_q;
		char_cnt_nx = char_cnt_q;
		hdr_nx = hdr_q;
		field_nx = field_q;
		acc_nx = acc_q;
		neg_nx = neg_q;
		point_nx = point_q;
		stop_nx = stop_q;
		fcnt_nx = fcnt_q;
		begun_nx = begun_q;
		pend_val_nx = pend_val_q;
		pend_side_nx = pend_side_q;
		status_ok_nx = status_ok_q;
		held_val_nx = held_val_q;
		held_side_nx = held_side_q;
		res_fire = 1'b0;
		res_data = '0;
		kind = 2'(phase_q - PH_GGA);
		latf = lat_field(kind);
		commit = 1'b0;

		if (accept) begin
			unique case (phase_q)
				PH_SEARCH: begin
					if (sym == CH_DOLLAR) begin
						char_cnt_nx = 8'd1;
						field_nx = '0;
						acc_nx = '0;
						neg_nx = 1'b0;
						point_nx = 1'b0;
						stop_nx = 1'b0;
						fcnt_nx = '0;
						begun_nx = 1'b0;
						pend_val_nx = '{default: '0};
						pend_side_nx = '{default: '0};
						status_ok_nx = 1'b0;
						phase_nx = PH_TALKER;
					end
				end
				PH_TALKER, PH_TYPE: begin
					for (int i = 0; i < HDR_DEPTH; i++) begin
						if (hdr_idx == 3'(i)) begin
							hdr_nx[i] = sym;
						end
					end
					char_cnt_nx = char_cnt_q + 8'd1;
					if (char_cnt_nx == 8'd3) begin
						phase_nx = (hdr_nx[0] == CH_G && hdr_nx[1] == CH_P)
							? PH_TYPE : PH_SEARCH;
					end else if (char_cnt_nx >= 8'd6) begin
						if (hdr_nx[2] == CH_G && hdr_nx[3] == CH_G && hdr_nx[4] == CH_A) begin
							phase_nx = PH_GGA;
						end else if (hdr_nx[2] == CH_G && hdr_nx[3] == CH_L
							&& hdr_nx[4] == CH_L) begin
							phase_nx = PH_GLL;
						end else if (hdr_nx[2] == CH_R && hdr_nx[3] == CH_M
							&& hdr_nx[4] == CH_C) begin
							phase_nx = PH_RMC;
						end else begin
							phase_nx = PH_SEARCH;
						end
					end
					if (phase_nx == PH_SEARCH) begin
						char_cnt_nx = '0;
					end
				end
				PH_GGA, PH_GLL, PH_RMC: begin
					if (char_cnt_q >= CNT_W'(MAX_SENTENCE)) begin
						phase_nx = PH_SEARCH;
						char_cnt_nx = '0;
					end else begin
						char_cnt_nx = char_cnt_q + 8'd1;
						if (sym == CH_COMMA || sym == CH_NL) begin
							// The field closes: store its number if it is one we keep.
							if (field_q == latf) begin
								pend_val_nx[0] = fix_val;
							end else if (field_q == latf + 5'd2) begin
								pend_val_nx[1] = fix_val;
							end else if (kind == KIND_GGA && field_q == GGA_ALT_FIELD) begin
								pend_val_nx[2] = fix_val;
							end
							acc_nx = '0;
							neg_nx = 1'b0;
							point_nx = 1'b0;
							stop_nx = 1'b0;
							fcnt_nx = '0;
							begun_nx = 1'b0;
							if (sym == CH_COMMA) begin
								if (field_q != FIELD_MAX) begin
									field_nx = field_q + 5'd1;
								end
							end else begin
								commit = (kind == KIND_GGA) || status_ok_q;
								if (commit) begin
									held_val_nx[0] = pend_val_nx[0];
									held_val_nx[1] = pend_val_nx[1];
									if (kind == KIND_GGA) begin
										held_val_nx[2] = pend_val_nx[2];
									end
									held_side_nx = pend_side_nx;
								end
								phase_nx = PH_SEARCH;
								char_cnt_nx = '0;
								res_fire = 1'b1;
								res_data.sentence_kind = kind;
								res_data.fix_committed = commit;
								res_data.latitude_fixed = held_val_nx[0];
								res_data.lat_hemisphere = held_side_nx[0];
								res_data.longitude_fixed = held_val_nx[1];
								res_data.lon_hemisphere = held_side_nx[1];
								res_data.altitude_fixed = held_val_nx[2];
							end
						end else begin
							// The first character of a field may be a side or status letter.
							if (!begun_q) begin
								if (field_q == latf + 5'd1) begin
									pend_side_nx[0] = sym;
								end else if (field_q == latf + 5'd3) begin
									pend_side_nx[1] = sym;
								end else if (kind != KIND_GGA && field_q == status_field(kind)) begin
									status_ok_nx = (sym == CH_A);
								end
							end
							if (!stop_q) begin
								if (is_digit) begin
									if (!point_q) begin
										acc_nx = acc_digit;
									end else if (fcnt_q < FRAC_CNT_W'(FRAC_DIGITS)) begin
										acc_nx = acc_digit;
										fcnt_nx = fcnt_q + 3'd1;
									end
								end else if (sym == CH_POINT && !point_q) begin
									point_nx = 1'b1;
								end else if ((sym == CH_MINUS || sym == CH_PLUS) && !begun_q) begin
									if (sym == CH_MINUS) begin
										neg_nx = 1'b1;
									end
								end else begin
									stop_nx = 1'b1;
								end
							end
							begun_nx = 1'b1;
						end
					end
				end
				default: begin
					phase_nx = PH_SEARCH;
					char_cnt_nx = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			char_cnt_q <= '0;
			field_q <= '0;
			acc_q <= '0;
			neg_q <= 1'b0;
			point_q <= 1'b0;
			stop_q <= 1'b0;
			fcnt_q <= '0;
			begun_q <= 1'b0;
			pend_val_q <= '{default: '0};
			pend_side_q <= '{default: '0};
			status_ok_q <= 1'b0;
			held_val_q <= '{default: '0};
			held_side_q <= '{default: '0};
		end else begin
			phase_q <= phase_nx;
			char_cnt_q <= char_cnt_nx;
			field_q <= field_nx;
			acc_q <= acc_nx;
			neg_q <= neg_nx;
			point_q <= point_nx;
			stop_q <= stop_nx;
			fcnt_q <= fcnt_nx;
			begun_q <= begun_nx;
			pend_val_q <= pend_val_nx;
			pend_side_q <= pend_side_nx;
			status_ok_q <= status_ok_nx;
			held_val_q <= held_val_nx;
			held_side_q <= held_side_nx;
		end
	end

	// Header bytes are always written before they are compared.
	always_ff @(posedge clk) begin
		hdr_q <= hdr_nx;
	end

	ngps_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_fire),
		.push_data(res_data),
		.full(full),
		.pop_valid(results.valid),
		.pop_ready(results.ready),
		.pop_data(pop_data)
	);

	assign results.sentence_kind = pop_data.sentence_kind;
	assign results.fix_committed = pop_data.fix_committed;
	assign results.latitude_fixed = pop_data.latitude_fixed;
	assign results.lat_hemisphere = pop_data.lat_hemisphere;
	assign results.longitude_fixed = pop_data.longitude_fixed;
	assign results.lon_hemisphere = pop_data.lon_hemisphere;
	assign results.altitude_fixed = pop_data.altitude_fixed;

endmodule

`default_nettype wire

// ----- hw/rtl/ngps_outq.sv -----
// Two-entry result queue that decouples the parser from a stalled sink.
// Depends on ngps_pkg for the result word type.
`default_nettype none

module ngps_outq import ngps_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input result_t push_data,
	output logic full,
	output logic pop_valid,
	input logic pop_ready,
	output result_t pop_data
);

	result_t ent_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;
	logic pop;

	assign pop = pop_valid && pop_ready;
	assign pop_valid = (cnt_q != 2'd0);
	assign full = (cnt_q == 2'd2);
	assign pop_data = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire
